/* hdl/apafc_pkg.sv */
// shared types, codes and constants for the led strip frame controller
`default_nettype none

package apafc_pkg;

	localparam logic [2:0] KIND_SET     = 3'd0;
	localparam logic [2:0] KIND_ROTATE  = 3'd1;
	localparam logic [2:0] KIND_REFRESH = 3'd2;
	localparam logic [2:0] KIND_PULL    = 3'd3;
	localparam logic [2:0] KIND_CLEAR   = 3'd4;

	localparam int unsigned FRAME_EDGE_BYTES = 4;
	localparam logic [7:0]  BRIGHT_MARK      = 8'hE0;
	localparam logic [7:0]  END_FILL         = 8'hFF;
	localparam logic [7:0]  START_FILL       = 8'h00;
	localparam logic [31:0] BLANK_WORD       = {24'h000000, BRIGHT_MARK};

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = 2;

	localparam logic [7:0] GAMMA [256] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
		8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
		8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
		8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
		8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
		8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
		8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
		8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
		8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
		8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
		8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
		8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
		8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
		8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
		8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
		8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
		8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
		8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
		8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
		8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
		8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
		8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
		8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
		8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
		8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
		8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
		8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
	};

	typedef enum logic [2:0] {
		OP_SET,
		OP_ROTATE,
		OP_REFRESH,
		OP_PULL,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  idx;
		logic [31:0] word;
		logic        dir;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_FILL,
		BK_RUN,
		BK_ROT,
		BK_ROT_LAST
	} back_st_t;

	typedef enum logic [1:0] {
		CLS_START,
		CLS_PIXEL,
		CLS_END
	} byte_cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

/* hdl/apafc_front.sv */
// request decode, range check and gamma packing ahead of the command queue
`default_nettype none

module apafc_front #(
	parameter int unsigned MAX_LEDS = 256
) (
	input  wire logic                           start,
	input  wire logic [2:0]                     kind,
	input  wire logic [7:0]                     pixel_index,
	input  wire logic [7:0]                     bright_level,
	input  wire logic [7:0]                     red_level,
	input  wire logic [7:0]                     green_level,
	input  wire logic [7:0]                     blue_level,
	input  wire logic                           direction,
	input  wire logic [$clog2(MAX_LEDS+1)-1:0]  n,
	input  wire apafc_pkg::q_status_t           q_status,
	input  wire logic                           init_busy,
	output logic                                busy,
	output logic                                push,
	output apafc_pkg::cmd_t                     cmd
);

	localparam int unsigned CW   = $clog2(MAX_LEDS + 1);
	localparam int unsigned CMPW = (CW > 8) ? CW : 8;

	logic accept;
	logic keep;

	assign busy   = q_status.full | init_busy;
	assign accept = start & ~busy;
	assign push   = accept & keep;

	always_comb begin
		keep     = 1'b0;
		cmd.op   = apafc_pkg::OP_SET;
		cmd.idx  = pixel_index;
		cmd.dir  = direction;
		cmd.word = {apafc_pkg::GAMMA[red_level], apafc_pkg::GAMMA[green_level],
			apafc_pkg::GAMMA[blue_level], bright_level | apafc_pkg::BRIGHT_MARK};
		unique case (kind)
			apafc_pkg::KIND_SET: begin
				cmd.op = apafc_pkg::OP_SET;
				keep   = CMPW'(pixel_index) < CMPW'(n);
			end
			apafc_pkg::KIND_ROTATE: begin
				cmd.op = apafc_pkg::OP_ROTATE;
				keep   = 1'b1;
			end
			apafc_pkg::KIND_REFRESH: begin
				cmd.op = apafc_pkg::OP_REFRESH;
				keep   = 1'b1;
			end
			apafc_pkg::KIND_PULL: begin
				cmd.op = apafc_pkg::OP_PULL;
				keep   = 1'b1;
			end
			apafc_pkg::KIND_CLEAR: begin
				cmd.op = apafc_pkg::OP_CLEAR;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/apafc_queue.sv */
// short command queue between the front and the back
`default_nettype none

module apafc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire apafc_pkg::cmd_t  wr_cmd,
	input  wire logic             pop,
	output apafc_pkg::cmd_t       head,
	output apafc_pkg::q_status_t  status
);

	apafc_pkg::cmd_t              slots_q [apafc_pkg::QDEPTH];
	logic [apafc_pkg::QAW-1:0]    rd_ptr_q;
	logic [apafc_pkg::QAW-1:0]    wr_ptr_q;
	logic [apafc_pkg::QAW:0]      count_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.full  = count_q == (apafc_pkg::QAW+1)'(apafc_pkg::QDEPTH);
	assign status.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

/* hdl/apafc_back.sv */
// pixel memory, fill and rotate sweeps, and frame byte serializer
`default_nettype none

module apafc_back #(
	parameter int unsigned MAX_LEDS = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [$clog2(MAX_LEDS+1)-1:0]  n,
	input  wire logic                           q_empty,
	input  wire apafc_pkg::cmd_t                head,
	output logic                                q_pop,
	output logic                                init_busy,
	output logic                                byte_valid,
	output logic [7:0]                          spi_byte,
	output logic                                last_byte
);

	localparam int unsigned AW        = $clog2(MAX_LEDS);
	localparam int unsigned CW        = $clog2(MAX_LEDS + 1);
	localparam int unsigned MAX_TOTAL = 4 + 4 * MAX_LEDS + (MAX_LEDS / 2 + 7) / 8;
	localparam int unsigned PW        = $clog2(MAX_TOTAL + 1);

	apafc_pkg::back_st_t  state_q;
	apafc_pkg::back_st_t  state_d;

	logic [31:0]      mem [MAX_LEDS];
	logic [31:0]      rdata_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    fill_last_q;
	logic             dir_q;
	logic             init_q;
	logic [31:0]      keep_q;
	logic [AW-1:0]    ra_s1;
	logic             sending_q;
	logic [PW-1:0]    pos_q;
	logic             pull_s1;
	apafc_pkg::byte_cls_t cls_s1;
	logic [1:0]       sel_s1;
	logic             last_s1;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [31:0]      wdata;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    n_last;
	logic             pull_go;

	logic [PW-1:0]    data_end;
	logic [PW-1:0]    tail_len;
	logic [PW-1:0]    total;
	logic [PW-1:0]    pos_next;
	logic             pull_last;
	apafc_pkg::byte_cls_t pull_cls;
	logic [AW-1:0]    pull_addr;
	logic [PW-1:0]    pos_off;

	assign n_last    = AW'(n - 1'b1);
	assign init_busy = init_q;

	// frame geometry for the current led count
	assign data_end  = PW'(apafc_pkg::FRAME_EDGE_BYTES) + (PW'(n) << 2);
	assign tail_len  = (PW'(n >> 1) + PW'(7)) >> 3;
	assign total     = data_end + tail_len;
	assign pos_next  = pos_q + 1'b1;
	assign pull_last = pos_next >= total;
	assign pos_off   = pos_q - PW'(apafc_pkg::FRAME_EDGE_BYTES);
	assign pull_addr = AW'(pos_off >> 2);

	always_comb begin
		if (pos_q < PW'(apafc_pkg::FRAME_EDGE_BYTES)) begin
			pull_cls = apafc_pkg::CLS_START;
		end else if (pos_q < data_end) begin
			pull_cls = apafc_pkg::CLS_PIXEL;
		end else begin
			pull_cls = apafc_pkg::CLS_END;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			apafc_pkg::BK_FILL: begin
				if (cnt_q == fill_last_q) begin
					state_d = apafc_pkg::BK_RUN;
				end
			end
			apafc_pkg::BK_RUN: begin
				if (!q_empty && head.op == apafc_pkg::OP_CLEAR) begin
					state_d = apafc_pkg::BK_FILL;
				end else if (!q_empty && head.op == apafc_pkg::OP_ROTATE) begin
					state_d = apafc_pkg::BK_ROT;
				end
			end
			apafc_pkg::BK_ROT: begin
				if (cnt_q == n) begin
					state_d = apafc_pkg::BK_ROT_LAST;
				end
			end
			apafc_pkg::BK_ROT_LAST: begin
				state_d = apafc_pkg::BK_RUN;
			end
			default: begin
				state_d = apafc_pkg::BK_RUN;
			end
		endcase
	end

	always_comb begin
		q_pop   = 1'b0;
		we      = 1'b0;
		waddr   = '0;
		wdata   = rdata_q;
		raddr   = pull_addr;
		pull_go = 1'b0;
		unique case (state_q)
			apafc_pkg::BK_FILL: begin
				we    = 1'b1;
				waddr = AW'(cnt_q);
				wdata = apafc_pkg::BLANK_WORD;
			end
			apafc_pkg::BK_RUN: begin
				q_pop = !q_empty;
				if (!q_empty && head.op == apafc_pkg::OP_SET) begin
					we    = 1'b1;
					waddr = AW'(head.idx);
					wdata = head.word;
				end
				pull_go = !q_empty && head.op == apafc_pkg::OP_PULL && sending_q;
			end
			apafc_pkg::BK_ROT: begin
				// first read is parked in keep_q, then each word moves one place
				raddr = dir_q ? AW'(n_last - AW'(cnt_q)) : AW'(cnt_q);
				if (cnt_q >= CW'(2)) begin
					we    = 1'b1;
					waddr = dir_q ? ra_s1 + 1'b1 : ra_s1 - 1'b1;
				end
			end
			apafc_pkg::BK_ROT_LAST: begin
				we    = 1'b1;
				waddr = dir_q ? '0 : n_last;
				wdata = keep_q;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= apafc_pkg::BK_FILL;
			cnt_q       <= '0;
			fill_last_q <= CW'(MAX_LEDS - 1);
			init_q      <= 1'b1;
			dir_q       <= 1'b0;
			sending_q   <= 1'b0;
			pos_q       <= '0;
			pull_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			pull_s1 <= pull_go;
			if (state_q == apafc_pkg::BK_FILL && state_d == apafc_pkg::BK_RUN) begin
				init_q <= 1'b0;
			end
			if (state_q == apafc_pkg::BK_RUN) begin
				cnt_q       <= '0;
				fill_last_q <= CW'(n_last);
				if (q_pop) begin
					dir_q <= head.dir;
				end
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (q_pop && (head.op == apafc_pkg::OP_REFRESH || head.op == apafc_pkg::OP_CLEAR))
			begin
				sending_q <= 1'b1;
				pos_q     <= '0;
			end else if (pull_go) begin
				if (pull_last) begin
					sending_q <= 1'b0;
					pos_q     <= '0;
				end else begin
					pos_q <= pos_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ra_s1   <= raddr;
		cls_s1  <= pull_cls;
		sel_s1  <= pos_q[1:0];
		last_s1 <= pull_last;
		if (state_q == apafc_pkg::BK_ROT && cnt_q == CW'(1)) begin
			keep_q <= rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign byte_valid = pull_s1;
	assign last_byte  = pull_s1 & last_s1;

	always_comb begin
		case (cls_s1)
			apafc_pkg::CLS_START: spi_byte = apafc_pkg::START_FILL;
			apafc_pkg::CLS_PIXEL: spi_byte = rdata_q[{sel_s1, 3'b000} +: 8];
			default:              spi_byte = apafc_pkg::END_FILL;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/apa102_strip_frame_controller_core.sv */
// top level of the led strip frame controller: config register, front, queue, back
//
// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+-------------------------------
// request   | in        | start, busy                    | kind, pixel_index, levels, dir
// result    | out       | byte_valid (one-cycle strobe)  | spi_byte, last_byte
// config    | in        | apb psel/penable/pwrite/pready | led_count at byte address 0
//
// set, refresh and pull leave the queue without a sweep; a pull result shows in the
// cycle after the pull leaves the queue.
// clear sweeps n memory words; rotate runs through the single read and single write
// port of the pixel memory.
// after reset a fill sweep writes all MAX_LEDS words with busy high.
// busy also rises when the four-entry request queue is full.
`default_nettype none

module apa102_strip_frame_controller_core #(
	parameter int unsigned MAX_LEDS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  pixel_index,
	input  wire logic [7:0]  bright_level,
	input  wire logic [7:0]  red_level,
	input  wire logic [7:0]  green_level,
	input  wire logic [7:0]  blue_level,
	input  wire logic        direction,
	output logic             byte_valid,
	output logic [7:0]       spi_byte,
	output logic             last_byte
);

	localparam int unsigned CW = $clog2(MAX_LEDS + 1);
	localparam int unsigned NW = (CW > 9) ? CW : 9;

	logic [8:0]            led_count_q;
	logic [NW-1:0]         lc_ext;
	logic [CW-1:0]         n;
	logic                  q_push;
	logic                  q_pop;
	logic                  init_busy;
	apafc_pkg::cmd_t       q_wr_cmd;
	apafc_pkg::cmd_t       q_head;
	apafc_pkg::q_status_t  q_status;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'h0 : {23'h0, led_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= 9'd256;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			led_count_q <= pwdata[8:0];
		end
	end

	assign lc_ext = NW'(led_count_q);

	always_comb begin
		if (lc_ext < NW'(2)) begin
			n = CW'(2);
		end else if (lc_ext > NW'(MAX_LEDS)) begin
			n = CW'(MAX_LEDS);
		end else begin
			n = CW'(lc_ext);
		end
	end

	apafc_front #(
		.MAX_LEDS (MAX_LEDS)
	) u_front (
		.start        (start),
		.kind         (kind),
		.pixel_index  (pixel_index),
		.bright_level (bright_level),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level),
		.direction    (direction),
		.n            (n),
		.q_status     (q_status),
		.init_busy    (init_busy),
		.busy         (busy),
		.push         (q_push),
		.cmd          (q_wr_cmd)
	);

	apafc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.pop    (q_pop),
		.head   (q_head),
		.status (q_status)
	);

	apafc_back #(
		.MAX_LEDS (MAX_LEDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.n          (n),
		.q_empty    (q_status.empty),
		.head       (q_head),
		.q_pop      (q_pop),
		.init_busy  (init_busy),
		.byte_valid (byte_valid),
		.spi_byte   (spi_byte),
		.last_byte  (last_byte)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("request queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("request queue read while empty");

	a_result_from_pull: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid |-> $past(q_pop && q_head.op == apafc_pkg::OP_PULL))
		else $error("result strobe without a pull leaving the queue");

	a_idle_during_fill: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !q_pop && busy)
		else $error("request taken during the reset fill sweep");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the led strip frame controller: scripted and random requests
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STRIP_LEDS = 256;
	localparam int unsigned KIND_CODES = 8;
	localparam logic [2:0] KIND_UNUSED = 3'd5;
	localparam logic [2:0] ADDR_COUNT = 3'd0;
	localparam logic [2:0] ADDR_SPARE = 3'd4;
	localparam int unsigned SETTLE_CYCLES = 1500;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] idx;
		logic [7:0] br;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       dir;
	} strip_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	typedef struct packed {
		logic       reg_wr;
		logic [2:0] addr;
		logic [8:0] wdata;
		logic [2:0] kind;
		logic [7:0] idx;
		logic [7:0] br;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       dir;
		logic [7:0] reps;
		logic       pinned;
		logic [7:0] want_byte;
		logic       want_last;
	} script_row_t;

	localparam int unsigned SCRIPT_LEN = 24;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, KIND_UNUSED,
			'1, '1, '1, '1, '1, '1, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_SET,
			8'd255, '0, '1, '1, '1, '0, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_REFRESH,
			'0, '0, '0, '0, '0, '0, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd4, '1, apafc_pkg::START_FILL, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd1, '1, apafc_pkg::BRIGHT_MARK, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_SET,
			'0, '1, '0, '0, '1, '0, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd1, '1, 8'hff, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_ROTATE,
			'0, '0, '0, '0, '0, '1, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd1, '1, 8'hff, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd6, '0, '0, '0},
		'{'1, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd0, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd1, '1, apafc_pkg::END_FILL, '1},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd1, '0, '0, '0},
		'{'1, ADDR_COUNT, 9'd3, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd0, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_SET,
			8'd3, 8'h12, 8'h34, 8'h56, 8'h78, '0, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_SET,
			8'd2, 8'h5a, 8'h80, 8'hc0, 8'h40, '0, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_ROTATE,
			'0, '0, '0, '0, '0, '0, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_REFRESH,
			'0, '0, '0, '0, '0, '0, 8'd1, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd2, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_REFRESH,
			'0, '0, '0, '0, '0, '0, 8'd1, '0, '0, '0},
		'{'1, ADDR_SPARE, '1, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd0, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_PULL,
			'0, '0, '0, '0, '0, '0, 8'd17, '0, '0, '0},
		'{'0, ADDR_COUNT, '0, apafc_pkg::KIND_CLEAR,
			'0, '0, '0, '0, '0, '0, 8'd1, '0, '0, '0}
	};

	localparam int unsigned PHASES = 11;
	localparam logic [8:0] PHASE_COUNT [PHASES] = '{
		9'd4, 9'd2, 9'd7, 9'd1, 9'd16, 9'd511, 9'd0, 9'd5, 9'd33, 9'd3, 9'd300
	};
	localparam int unsigned PHASE_ITEMS [PHASES] = '{
		60, 60, 60, 60, 60, 1050, 60, 60, 60, 60, 60
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [7:0]  pixel_index;
	logic [7:0]  bright_level;
	logic [7:0]  red_level;
	logic [7:0]  green_level;
	logic [7:0]  blue_level;
	logic        direction;
	logic        byte_valid;
	logic [7:0]  spi_byte;
	logic        last_byte;

	apa102_strip_frame_controller_core #(
		.MAX_LEDS(STRIP_LEDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.kind(kind),
		.pixel_index(pixel_index),
		.bright_level(bright_level),
		.red_level(red_level),
		.green_level(green_level),
		.blue_level(blue_level),
		.direction(direction),
		.byte_valid(byte_valid),
		.spi_byte(spi_byte),
		.last_byte(last_byte)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [31:0]  shadow_pixels [STRIP_LEDS];
	logic [8:0]   shadow_count;
	bit           shadow_sending;
	int unsigned  shadow_pos;
	frame_byte_t  pending_bytes [$];
	bit           pinned_on;
	frame_byte_t  pinned_byte;
	int unsigned  applied_items;
	int unsigned  issued_items;
	int unsigned  idle_pct;
	int unsigned  fail_count;
	int unsigned  cycle_count;

	function automatic int unsigned live_count();
		if (shadow_count < 2)
			return 2;
		if (shadow_count > STRIP_LEDS)
			return STRIP_LEDS;
		return shadow_count;
	endfunction

	function automatic int unsigned frame_total(input int unsigned n);
		return apafc_pkg::FRAME_EDGE_BYTES * (n + 1) + (n / 2 + 7) / 8;
	endfunction

	function automatic bit predict_frame_byte(input strip_req_t q, output frame_byte_t fb,
			output bit effective);
		int unsigned n;
		int unsigned off;
		logic [31:0] keep;
		bit emits;
		n = live_count();
		emits = 1'b0;
		effective = 1'b1;
		fb = '0;
		case (q.kind)
			apafc_pkg::KIND_SET: begin
				if (q.idx < n)
					shadow_pixels[q.idx] = {apafc_pkg::GAMMA[q.red],
						apafc_pkg::GAMMA[q.green], apafc_pkg::GAMMA[q.blue],
						q.br | apafc_pkg::BRIGHT_MARK};
				else
					effective = 1'b0;
			end
			apafc_pkg::KIND_ROTATE: begin
				if (q.dir) begin
					keep = shadow_pixels[n - 1];
					for (int i = n - 1; i > 0; i--)
						shadow_pixels[i] = shadow_pixels[i - 1];
					shadow_pixels[0] = keep;
				end else begin
					keep = shadow_pixels[0];
					for (int i = 0; i + 1 < n; i++)
						shadow_pixels[i] = shadow_pixels[i + 1];
					shadow_pixels[n - 1] = keep;
				end
			end
			apafc_pkg::KIND_REFRESH: begin
				shadow_sending = 1'b1;
				shadow_pos = 0;
			end
			apafc_pkg::KIND_PULL: begin
				if (!shadow_sending) begin
					effective = 1'b0;
				end else begin
					if (shadow_pos < apafc_pkg::FRAME_EDGE_BYTES) begin
						fb.data = apafc_pkg::START_FILL;
					end else if (shadow_pos < apafc_pkg::FRAME_EDGE_BYTES * (n + 1)) begin
						off = shadow_pos - apafc_pkg::FRAME_EDGE_BYTES;
						fb.data = shadow_pixels[off / 4][8 * (off % 4) +: 8];
					end else begin
						fb.data = apafc_pkg::END_FILL;
					end
					fb.last = (shadow_pos + 1 >= frame_total(n));
					shadow_pos = fb.last ? 0 : shadow_pos + 1;
					if (fb.last)
						shadow_sending = 1'b0;
					emits = 1'b1;
				end
			end
			apafc_pkg::KIND_CLEAR: begin
				for (int i = 0; i < n; i++)
					shadow_pixels[i] = apafc_pkg::BLANK_WORD;
				shadow_sending = 1'b1;
				shadow_pos = 0;
			end
			default: effective = 1'b0;
		endcase
		return emits;
	endfunction

	always @(posedge clk) begin : result_check
		strip_req_t q;
		frame_byte_t fb;
		frame_byte_t want;
		bit effective;
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
		if (arst_n && byte_valid) begin
			if (pending_bytes.size() == 0) begin
				$error("spi_byte: expected no result, got %02h", spi_byte);
				fail_count++;
			end else begin
				want = pending_bytes.pop_front();
				if (spi_byte !== want.data) begin
					$error("spi_byte: expected %02h, got %02h", want.data, spi_byte);
					fail_count++;
				end
				if (last_byte !== want.last) begin
					$error("last_byte: expected %0b, got %0b", want.last, last_byte);
					fail_count++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			q = '{kind, pixel_index, bright_level, red_level, green_level, blue_level,
				direction};
			if (predict_frame_byte(q, fb, effective))
				pending_bytes.push_back(pinned_on ? pinned_byte : fb);
			if (effective)
				applied_items++;
		end
	end

	function automatic strip_req_t make_req(input logic [2:0] k, input int unsigned n);
		strip_req_t q;
		q.kind = k;
		if ($urandom_range(3) == 0)
			q.idx = 8'($urandom_range(255));
		else
			q.idx = 8'($urandom_range(n < 255 ? n : 255));
		q.br = 8'($urandom);
		q.red = 8'($urandom);
		q.green = 8'($urandom);
		q.blue = 8'($urandom);
		q.dir = 1'($urandom);
		return q;
	endfunction

	function automatic logic [2:0] pick_kind(input bit wide_frame);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < (wide_frame ? 90 : 75))
			return apafc_pkg::KIND_PULL;
		roll = $urandom_range(99);
		if (roll < 60)
			return apafc_pkg::KIND_SET;
		if (roll < 82)
			return apafc_pkg::KIND_ROTATE;
		if (roll < 90)
			return 3'($urandom_range(apafc_pkg::KIND_CLEAR + 1, KIND_CODES - 1));
		if (wide_frame)
			return apafc_pkg::KIND_SET;
		return (roll < 96) ? apafc_pkg::KIND_REFRESH : apafc_pkg::KIND_CLEAR;
	endfunction

	task automatic drive_fields(input strip_req_t q);
		kind <= q.kind;
		pixel_index <= q.idx;
		bright_level <= q.br;
		red_level <= q.red;
		green_level <= q.green;
		blue_level <= q.blue;
		direction <= q.dir;
	endtask

	task automatic issue(input strip_req_t q);
		idle_pct = (issued_items < 650) ? 28 : (issued_items < 1300) ? 67 : 0;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			drive_fields(make_req(3'($urandom_range(KIND_CODES - 1)), 255));
			@(negedge clk);
		end
		start <= 1'b1;
		drive_fields(q);
		do @(posedge clk); while (busy);
		issued_items++;
		@(negedge clk);
	endtask

	task automatic wait_for_bytes();
		start <= 1'b0;
		@(negedge clk);
		while (pending_bytes.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		wait_for_bytes();
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_COUNT)
			shadow_count = value[8:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned budget);
		int unsigned n;
		int unsigned stop_at;
		int unsigned pulls;
		int unsigned goal;
		bit wide_frame;
		strip_req_t q;
		n = live_count();
		stop_at = applied_items + budget;
		wide_frame = frame_total(n) > 200;
		while (applied_items < stop_at) begin
			issue(make_req(($urandom_range(9) == 0) ? apafc_pkg::KIND_CLEAR
				: apafc_pkg::KIND_REFRESH, n));
			goal = frame_total(n) + $urandom_range(3);
			pulls = 0;
			while (pulls < goal && applied_items < stop_at) begin
				q = make_req(pick_kind(wide_frame), n);
				if (q.kind == apafc_pkg::KIND_PULL)
					pulls++;
				issue(q);
			end
			if ($urandom_range(19) == 0)
				wait_for_bytes();
		end
	endtask

	initial begin
		script_row_t row;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		kind = apafc_pkg::KIND_SET;
		pixel_index = '0;
		bright_level = '0;
		red_level = '0;
		green_level = '0;
		blue_level = '0;
		direction = 1'b0;
		shadow_count = 9'(STRIP_LEDS);
		for (int i = 0; i < STRIP_LEDS; i++)
			shadow_pixels[i] = apafc_pkg::BLANK_WORD;
		shadow_sending = 1'b0;
		shadow_pos = 0;
		pinned_on = 1'b0;
		pinned_byte = '0;
		applied_items = 0;
		issued_items = 0;
		fail_count = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < SCRIPT_LEN; r++) begin
			row = SCRIPT[r];
			if (row.reg_wr) begin
				write_reg(row.addr, 32'(row.wdata));
			end else begin
				pinned_on = row.pinned;
				pinned_byte = '{row.want_byte, row.want_last};
				for (int k = 0; k < row.reps; k++)
					issue(strip_req_t'{row.kind, row.idx, row.br, row.red, row.green,
						row.blue, row.dir});
			end
		end
		pinned_on = 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			write_reg(ADDR_COUNT, ($urandom() & ~32'h1ff) | 32'(PHASE_COUNT[p]));
			run_phase(PHASE_ITEMS[p]);
		end

		wait_for_bytes();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
